// ----- sv/dca_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and calendar helper functions for the date unit.
// Used by every pipeline module; depends on nothing.
package dca_pkg;

    localparam int YEAR_FLOOR = 1;

    // 25 is odd, so it has an inverse mod 2^16; y*INV25 lands at or below
    // DIV25_MAX exactly when y is a multiple of 25
    localparam logic [15:0] INV25     = 16'd23593;
    localparam logic [15:0] DIV25_MAX = 16'd2621;

    typedef logic [15:0] year_t;
    typedef logic [24:0] dnum_t;

    typedef enum logic [1:0] {
        MODE_DAYS   = 2'd0,
        MODE_MONTHS = 2'd1,
        MODE_YEARS  = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    typedef struct packed {
        logic       day_mode;
        dnum_t      dn;
        year_t      alt_y;
        logic [3:0] alt_m;
        logic [4:0] alt_d;
        logic       sat;
        logic       in_ok;
    } norm_out_t;

    typedef struct packed {
        year_t      y;
        logic [3:0] m;
        logic [4:0] d;
        logic       sat;
        logic       in_ok;
    } date_out_t;

    function automatic logic is_leap(input year_t y);
        logic [15:0] prod;
        logic        div25;
        begin
            prod  = 16'(y * INV25);
            div25 = (prod <= DIV25_MAX);
            return (y[1:0] == 2'd0) && (!div25 || (y[3:0] == 4'd0));
        end
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        begin
            unique case (m)
                4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
                4'd2:                    len = leap ? 5'd29 : 5'd28;
                default:                 len = 5'd31;
            endcase
            return len;
        end
    endfunction

    // days in the year before the first of month m
    function automatic logic [8:0] ordinal(input logic [3:0] m, input logic leap);
        logic [8:0] base;
        begin
            unique case (m)
                4'd2:    base = 9'd31;
                4'd3:    base = 9'd59;
                4'd4:    base = 9'd90;
                4'd5:    base = 9'd120;
                4'd6:    base = 9'd151;
                4'd7:    base = 9'd181;
                4'd8:    base = 9'd212;
                4'd9:    base = 9'd243;
                4'd10:   base = 9'd273;
                4'd11:   base = 9'd304;
                4'd12:   base = 9'd334;
                default: base = 9'd0;
            endcase
            return base + 9'((m > 4'd2) && leap);
        end
    endfunction

    // estimate of p/100, low by at most one
    function automatic logic [9:0] q100_est(input year_t p);
        logic [25:0] prod;
        begin
            prod = 26'(p) * 26'd655;
            return prod[25:16];
        end
    endfunction

    // days from year 1 to January 1 of year p+1
    function automatic dnum_t dby_fix(input year_t p, input logic [9:0] qe);
        logic [16:0] r;
        logic [9:0]  q;
        begin
            r = 17'(p) - 17'(qe) * 17'd100;
            q = (r >= 17'd100) ? qe + 10'd1 : qe;
            return 25'(p) * 25'd365 + 25'(p >> 2) - 25'(q) + 25'(q >> 2);
        end
    endfunction

    // x mod 7 given an estimate of x/7 low by at most one
    function automatic logic [2:0] mod7_fix(input dnum_t x, input logic [22:0] qe);
        logic [24:0] r;
        begin
            r = x - 25'(qe) * 25'd7;
            return (r[3:0] >= 4'd7) ? 3'(r[3:0] - 4'd7) : r[2:0];
        end
    endfunction

endpackage

// ----- sv/dca_norm.sv -----
`timescale 1ns / 1ps
// Front stages: input clamping and check, day number and month/year adds.
// Depends on dca_pkg.
module dca_norm import dca_pkg::*; #(
    parameter int YEAR_LIMIT = 9999
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         mode,
    input  logic [13:0]        year,
    input  logic [3:0]         month,
    input  logic [4:0]         day,
    input  logic signed [22:0] offset,
    output logic               out_valid,
    input  logic               out_stall,
    output norm_out_t          out_data
);

    localparam int NS = 4;
    localparam year_t YMAX = year_t'(YEAR_LIMIT);
    localparam year_t YMIN = year_t'(YEAR_FLOOR);
    localparam logic signed [26:0] T1_MIN = 27'(YEAR_FLOOR * 12);
    localparam logic signed [26:0] T1_MAX = 27'(YEAR_LIMIT * 12 + 11);
    localparam logic signed [26:0] T2_MIN = 27'(YEAR_FLOOR);
    localparam logic signed [26:0] T2_MAX = 27'(YEAR_LIMIT);
    localparam int DN_HI_I = YEAR_LIMIT * 365 + YEAR_LIMIT / 4 - YEAR_LIMIT / 100
                             + YEAR_LIMIT / 400 - 1;
    localparam logic signed [26:0] DN_HI = 27'(DN_HI_I);

    logic [NS-1:0] v_reg;
    logic [NS:0]   hold;
    logic [NS-1:0] en;

    always_comb
    begin
        hold[NS] = out_stall;
        for (int k = NS - 1; k >= 0; k--)
        begin
            hold[k] = v_reg[k] & hold[k+1];
        end
        en = ~hold[NS-1:0];
    end

    assign in_stall  = hold[0];
    assign out_valid = v_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // stage A: clamp and check
    year_t             y_ext;
    year_t             a_y_next;
    logic [3:0]        a_m_next;
    logic [4:0]        a_d_next;
    logic              a_leap_next;
    logic [4:0]        a_mlen;
    mode_t             a_mode_reg;
    year_t             a_y_reg;
    logic [3:0]        a_m_reg;
    logic [4:0]        a_d_reg;
    logic signed [22:0] a_off_reg;
    logic              a_ok_reg;
    logic              a_leap_reg;

    always_comb
    begin
        y_ext       = year_t'(year);
        a_y_next    = (y_ext < YMIN) ? YMIN : ((y_ext > YMAX) ? YMAX : y_ext);
        a_m_next    = (month == 4'd0) ? 4'd1 : ((month > 4'd12) ? 4'd12 : month);
        a_leap_next = is_leap(a_y_next);
        a_mlen      = month_len(a_m_next, a_leap_next);
        a_d_next    = (day == 5'd0) ? 5'd1 : ((day > a_mlen) ? a_mlen : day);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            a_mode_reg <= mode_t'(mode);
            a_y_reg    <= a_y_next;
            a_m_reg    <= a_m_next;
            a_d_reg    <= a_d_next;
            a_off_reg  <= offset;
            a_ok_reg   <= (y_ext == a_y_next) && (month == a_m_next) && (day == a_d_next);
            a_leap_reg <= a_leap_next;
        end
    end

    // stage B
    year_t              b_p_next;
    mode_t              b_mode_reg;
    year_t              b_y_reg;
    logic [3:0]         b_m_reg;
    logic [4:0]         b_d_reg;
    logic signed [22:0] b_off_reg;
    logic               b_ok_reg;
    year_t              b_p_reg;
    logic [9:0]         b_qe_reg;
    logic [8:0]         b_ord_reg;
    logic signed [26:0] b_t1_reg;
    logic signed [26:0] b_t2_reg;

    assign b_p_next = a_y_reg - 16'd1;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            b_mode_reg <= a_mode_reg;
            b_y_reg    <= a_y_reg;
            b_m_reg    <= a_m_reg;
            b_d_reg    <= a_d_reg;
            b_off_reg  <= a_off_reg;
            b_ok_reg   <= a_ok_reg;
            b_p_reg    <= b_p_next;
            b_qe_reg   <= q100_est(b_p_next);
            b_ord_reg  <= ordinal(a_m_reg, a_leap_reg);
            b_t1_reg   <= 27'(a_y_reg) * 27'd12 + 27'(a_m_reg) - 27'd1 + 27'(a_off_reg);
            b_t2_reg   <= 27'(a_y_reg) + 27'(a_off_reg);
        end
    end

    // stage C
    logic [36:0]        c_prod;
    mode_t              c_mode_reg;
    year_t              c_y_reg;
    logic [3:0]         c_m_reg;
    logic [4:0]         c_d_reg;
    logic signed [22:0] c_off_reg;
    logic               c_ok_reg;
    dnum_t              c_dby_reg;
    logic [8:0]         c_ord_reg;
    logic               c_lo1_reg;
    logic               c_hi1_reg;
    logic               c_lo2_reg;
    logic               c_hi2_reg;
    logic [19:0]        c_u_reg;
    logic [15:0]        c_q12e_reg;
    year_t              c_ny2_reg;

    assign c_prod = 37'(b_t1_reg[19:0]) * 37'd87381;

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            c_mode_reg <= b_mode_reg;
            c_y_reg    <= b_y_reg;
            c_m_reg    <= b_m_reg;
            c_d_reg    <= b_d_reg;
            c_off_reg  <= b_off_reg;
            c_ok_reg   <= b_ok_reg;
            c_dby_reg  <= dby_fix(b_p_reg, b_qe_reg);
            c_ord_reg  <= b_ord_reg;
            c_lo1_reg  <= b_t1_reg < T1_MIN;
            c_hi1_reg  <= b_t1_reg > T1_MAX;
            c_lo2_reg  <= b_t2_reg < T2_MIN;
            c_hi2_reg  <= b_t2_reg > T2_MAX;
            c_u_reg    <= b_t1_reg[19:0];
            c_q12e_reg <= c_prod[35:20];
            c_ny2_reg  <= b_t2_reg[15:0];
        end
    end

    // stage D
    logic signed [26:0] dn_s;
    logic               lo0;
    logic               hi0;
    logic [19:0]        r12;
    year_t              ny1;
    logic [3:0]         nm1;
    norm_out_t          d_next;
    norm_out_t          d_out_reg;

    always_comb
    begin
        dn_s = 27'(c_dby_reg) + 27'(c_ord_reg) + 27'(c_d_reg) - 27'd1 + 27'(c_off_reg);
        lo0  = dn_s < 27'sd0;
        hi0  = dn_s > DN_HI;
        r12  = c_u_reg - 20'(c_q12e_reg) * 20'd12;
        if (r12 >= 20'd12)
        begin
            ny1 = c_q12e_reg + 16'd1;
            nm1 = 4'(r12 - 20'd12) + 4'd1;
        end
        else
        begin
            ny1 = c_q12e_reg;
            nm1 = r12[3:0] + 4'd1;
        end

        d_next.day_mode = (c_mode_reg == MODE_DAYS);
        d_next.in_ok    = c_ok_reg;
        d_next.dn       = lo0 ? '0 : (hi0 ? DN_HI[24:0] : dn_s[24:0]);
        d_next.alt_y    = c_y_reg;
        d_next.alt_m    = c_m_reg;
        d_next.alt_d    = c_d_reg;
        d_next.sat      = 1'b0;
        unique case (c_mode_reg)
            MODE_DAYS:
            begin
                d_next.sat = lo0 | hi0;
            end
            MODE_MONTHS:
            begin
                priority if (c_lo1_reg)
                begin
                    d_next.alt_y = YMIN;
                    d_next.alt_m = 4'd1;
                    d_next.alt_d = 5'd1;
                    d_next.sat   = 1'b1;
                end
                else if (c_hi1_reg)
                begin
                    d_next.alt_y = YMAX;
                    d_next.alt_m = 4'd12;
                    d_next.alt_d = 5'd31;
                    d_next.sat   = 1'b1;
                end
                else
                begin
                    d_next.alt_y = ny1;
                    d_next.alt_m = nm1;
                end
            end
            MODE_YEARS:
            begin
                priority if (c_lo2_reg)
                begin
                    d_next.alt_y = YMIN;
                    d_next.alt_m = 4'd1;
                    d_next.alt_d = 5'd1;
                    d_next.sat   = 1'b1;
                end
                else if (c_hi2_reg)
                begin
                    d_next.alt_y = YMAX;
                    d_next.alt_m = 4'd12;
                    d_next.alt_d = 5'd31;
                    d_next.sat   = 1'b1;
                end
                else
                begin
                    d_next.alt_y = c_ny2_reg;
                end
            end
            MODE_NONE:
            begin
                d_next.sat = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            d_out_reg <= d_next;
        end
    end

    assign out_data = d_out_reg;

endmodule

// ----- sv/dca_fdn.sv -----
`timescale 1ns / 1ps
// Day number to calendar date in eight stages, plus day clamp of the
// month/year add result. Depends on dca_pkg.
module dca_fdn import dca_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  norm_out_t in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output date_out_t out_data
);

    localparam int NS = 8;

    logic [NS-1:0] v_reg;
    logic [NS:0]   hold;
    logic [NS-1:0] en;

    always_comb
    begin
        hold[NS] = out_stall;
        for (int k = NS - 1; k >= 0; k--)
        begin
            hold[k] = v_reg[k] & hold[k+1];
        end
        en = ~hold[NS-1:0];
    end

    assign in_stall  = hold[0];
    assign out_valid = v_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // E: 400-year cycle estimate, clamp day of month/year result
    logic [32:0] e_prod;
    logic [4:0]  e_mlen;
    norm_out_t   e_car_next;
    norm_out_t   e_car_reg;
    logic [7:0]  e_q_reg;

    always_comb
    begin
        e_prod     = 33'(in_data.dn) * 33'd229;
        e_mlen     = month_len(in_data.alt_m, is_leap(in_data.alt_y));
        e_car_next = in_data;
        if (in_data.alt_d > e_mlen)
        begin
            e_car_next.alt_d = e_mlen;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            e_car_reg <= e_car_next;
            e_q_reg   <= e_prod[32:25];
        end
    end

    // F
    logic [25:0] f_rraw;
    norm_out_t   f_car_reg;
    logic [7:0]  f_n400_reg;
    logic [17:0] f_r_reg;

    assign f_rraw = 26'(e_car_reg.dn) - 26'(e_q_reg) * 26'd146097;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            f_car_reg <= e_car_reg;
            if (f_rraw >= 26'd146097)
            begin
                f_n400_reg <= e_q_reg + 8'd1;
                f_r_reg    <= 18'(f_rraw - 26'd146097);
            end
            else
            begin
                f_n400_reg <= e_q_reg;
                f_r_reg    <= 18'(f_rraw);
            end
        end
    end

    // G: century
    logic [1:0]  g_n100_next;
    logic [17:0] g_rraw;
    norm_out_t   g_car_reg;
    logic [7:0]  g_n400_reg;
    logic [1:0]  g_n100_reg;
    logic [15:0] g_r_reg;

    always_comb
    begin
        g_n100_next = (f_r_reg >= 18'd109572) ? 2'd3 :
                      (f_r_reg >= 18'd73048)  ? 2'd2 :
                      (f_r_reg >= 18'd36524)  ? 2'd1 : 2'd0;
        g_rraw      = f_r_reg - 18'(g_n100_next) * 18'd36524;
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            g_car_reg  <= f_car_reg;
            g_n400_reg <= f_n400_reg;
            g_n100_reg <= g_n100_next;
            g_r_reg    <= g_rraw[15:0];
        end
    end

    // H: 4-year estimate
    logic [21:0] h_prod;
    norm_out_t   h_car_reg;
    logic [7:0]  h_n400_reg;
    logic [1:0]  h_n100_reg;
    logic [15:0] h_r_reg;
    logic [4:0]  h_n4e_reg;

    assign h_prod = 22'(g_r_reg) * 22'd44;

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            h_car_reg  <= g_car_reg;
            h_n400_reg <= g_n400_reg;
            h_n100_reg <= g_n100_reg;
            h_r_reg    <= g_r_reg;
            h_n4e_reg  <= h_prod[20:16];
        end
    end

    // I
    logic [15:0] i_rraw;
    norm_out_t   i_car_reg;
    logic [7:0]  i_n400_reg;
    logic [1:0]  i_n100_reg;
    logic [4:0]  i_n4_reg;
    logic [10:0] i_r_reg;

    assign i_rraw = h_r_reg - 16'(h_n4e_reg) * 16'd1461;

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            i_car_reg  <= h_car_reg;
            i_n400_reg <= h_n400_reg;
            i_n100_reg <= h_n100_reg;
            if (i_rraw >= 16'd1461)
            begin
                i_n4_reg <= h_n4e_reg + 5'd1;
                i_r_reg  <= 11'(i_rraw - 16'd1461);
            end
            else
            begin
                i_n4_reg <= h_n4e_reg;
                i_r_reg  <= 11'(i_rraw);
            end
        end
    end

    // J: year within the 4-year group, assemble year
    logic [1:0]  j_n1;
    logic [10:0] j_rraw;
    logic [16:0] j_ysum;
    norm_out_t   j_car_reg;
    year_t       j_y_reg;
    logic [8:0]  j_r_reg;

    always_comb
    begin
        j_n1   = (i_r_reg >= 11'd1095) ? 2'd3 :
                 (i_r_reg >= 11'd730)  ? 2'd2 :
                 (i_r_reg >= 11'd365)  ? 2'd1 : 2'd0;
        j_rraw = i_r_reg - 11'(j_n1) * 11'd365;
        j_ysum = 17'(i_n400_reg) * 17'd400 + 17'(i_n100_reg) * 17'd100
                 + 17'(i_n4_reg) * 17'd4 + 17'(j_n1) + 17'd1;
    end

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            j_car_reg <= i_car_reg;
            j_y_reg   <= j_ysum[15:0];
            j_r_reg   <= j_rraw[8:0];
        end
    end

    // K
    norm_out_t k_car_reg;
    year_t     k_y_reg;
    logic [8:0] k_r_reg;
    logic      k_leap_reg;

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            k_car_reg  <= j_car_reg;
            k_y_reg    <= j_y_reg;
            k_r_reg    <= j_r_reg;
            k_leap_reg <= is_leap(j_y_reg);
        end
    end

    // L: month search, select result
    logic [3:0] l_mo;
    logic [8:0] l_dd;
    date_out_t  l_next;
    date_out_t  l_out_reg;

    always_comb
    begin
        l_mo = 4'd1;
        for (int i = 2; i <= 12; i++)
        begin
            if (ordinal(4'(i), k_leap_reg) <= k_r_reg)
            begin
                l_mo = 4'(i);
            end
        end
        l_dd         = k_r_reg - ordinal(l_mo, k_leap_reg) + 9'd1;
        l_next.sat   = k_car_reg.sat;
        l_next.in_ok = k_car_reg.in_ok;
        if (k_car_reg.day_mode)
        begin
            l_next.y = k_y_reg;
            l_next.m = l_mo;
            l_next.d = l_dd[4:0];
        end
        else
        begin
            l_next.y = k_car_reg.alt_y;
            l_next.m = k_car_reg.alt_m;
            l_next.d = k_car_reg.alt_d;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[7])
        begin
            l_out_reg <= l_next;
        end
    end

    assign out_data = l_out_reg;

endmodule

// ----- sv/dca_prop.sv -----
`timescale 1ns / 1ps
// Result date properties: leap, month length, day of year, weekday, week.
// Depends on dca_pkg.
module dca_prop import dca_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  date_out_t   in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [13:0] new_year,
    output logic [3:0]  new_month,
    output logic [4:0]  new_day,
    output logic [2:0]  weekday,
    output logic [8:0]  day_of_year,
    output logic [5:0]  week_of_year,
    output logic        leap_flag,
    output logic [4:0]  month_length,
    output logic        input_valid,
    output logic        range_flag
);

    localparam int NS = 5;

    logic [NS-1:0] v_reg;
    logic [NS:0]   hold;
    logic [NS-1:0] en;

    always_comb
    begin
        hold[NS] = out_stall;
        for (int k = NS - 1; k >= 0; k--)
        begin
            hold[k] = v_reg[k] & hold[k+1];
        end
        en = ~hold[NS-1:0];
    end

    assign in_stall  = hold[0];
    assign out_valid = v_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // stage 0
    year_t      p0_p_next;
    date_out_t  p0_car_reg;
    logic       p0_leap_reg;
    year_t      p0_p_reg;
    logic [9:0] p0_qe_reg;

    assign p0_p_next = in_data.y - 16'd1;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            p0_car_reg  <= in_data;
            p0_leap_reg <= is_leap(in_data.y);
            p0_p_reg    <= p0_p_next;
            p0_qe_reg   <= q100_est(p0_p_next);
        end
    end

    // stage 1
    date_out_t  p1_car_reg;
    logic       p1_leap_reg;
    dnum_t      p1_dby_reg;
    logic [8:0] p1_doy_reg;
    logic [4:0] p1_mlen_reg;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            p1_car_reg  <= p0_car_reg;
            p1_leap_reg <= p0_leap_reg;
            p1_dby_reg  <= dby_fix(p0_p_reg, p0_qe_reg);
            p1_doy_reg  <= ordinal(p0_car_reg.m, p0_leap_reg) + 9'(p0_car_reg.d);
            p1_mlen_reg <= month_len(p0_car_reg.m, p0_leap_reg);
        end
    end

    // stage 2: mod 7 estimates
    dnum_t       p2_x1_next;
    dnum_t       p2_x2_next;
    logic [47:0] p2_prod1;
    logic [47:0] p2_prod2;
    date_out_t   p2_car_reg;
    logic        p2_leap_reg;
    logic [8:0]  p2_doy_reg;
    logic [4:0]  p2_mlen_reg;
    dnum_t       p2_x1_reg;
    dnum_t       p2_x2_reg;
    logic [22:0] p2_q1_reg;
    logic [22:0] p2_q2_reg;

    always_comb
    begin
        p2_x1_next = p1_dby_reg + 25'd1;
        p2_x2_next = p1_dby_reg + 25'(p1_doy_reg);
        p2_prod1   = 48'(p2_x1_next) * 48'd4793490;
        p2_prod2   = 48'(p2_x2_next) * 48'd4793490;
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            p2_car_reg  <= p1_car_reg;
            p2_leap_reg <= p1_leap_reg;
            p2_doy_reg  <= p1_doy_reg;
            p2_mlen_reg <= p1_mlen_reg;
            p2_x1_reg   <= p2_x1_next;
            p2_x2_reg   <= p2_x2_next;
            p2_q1_reg   <= p2_prod1[47:25];
            p2_q2_reg   <= p2_prod2[47:25];
        end
    end

    // stage 3
    logic [2:0] p3_jan1;
    logic [2:0] p3_adj;
    date_out_t  p3_car_reg;
    logic       p3_leap_reg;
    logic [8:0] p3_doy_reg;
    logic [4:0] p3_mlen_reg;
    logic [2:0] p3_wd_reg;
    logic [8:0] p3_n_reg;

    always_comb
    begin
        p3_jan1 = mod7_fix(p2_x1_reg, p2_q1_reg);
        p3_adj  = (p3_jan1 == 3'd0) ? 3'd6 : p3_jan1 - 3'd1;
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            p3_car_reg  <= p2_car_reg;
            p3_leap_reg <= p2_leap_reg;
            p3_doy_reg  <= p2_doy_reg;
            p3_mlen_reg <= p2_mlen_reg;
            p3_wd_reg   <= mod7_fix(p2_x2_reg, p2_q2_reg);
            p3_n_reg    <= p2_doy_reg - 9'd1 + 9'(p3_adj);
        end
    end

    // stage 4: week number, n/7 as n*293>>11 (exact below 685)
    logic [17:0] p4_prod;
    date_out_t   o_car_reg;
    logic        o_leap_reg;
    logic [8:0]  o_doy_reg;
    logic [4:0]  o_mlen_reg;
    logic [2:0]  o_wd_reg;
    logic [5:0]  o_week_reg;

    assign p4_prod = 18'(p3_n_reg) * 18'd293;

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            o_car_reg  <= p3_car_reg;
            o_leap_reg <= p3_leap_reg;
            o_doy_reg  <= p3_doy_reg;
            o_mlen_reg <= p3_mlen_reg;
            o_wd_reg   <= p3_wd_reg;
            o_week_reg <= 6'(p4_prod[17:11]) + 6'd1;
        end
    end

    assign new_year     = o_car_reg.y[13:0];
    assign new_month    = o_car_reg.m;
    assign new_day      = o_car_reg.d;
    assign weekday      = o_wd_reg;
    assign day_of_year  = o_doy_reg;
    assign week_of_year = o_week_reg;
    assign leap_flag    = o_leap_reg;
    assign month_length = o_mlen_reg;
    assign input_valid  = o_car_reg.in_ok;
    assign range_flag   = o_car_reg.sat;

endmodule

// ----- sv/calendar_date_arithmetic_unit.sv -----
`timescale 1ns / 1ps
// Top level of the Gregorian date add and weekday unit.
// Depends on dca_pkg, dca_norm, dca_fdn and dca_prop.

// A fully pipelined unit: one transaction is accepted every clock cycle
// unless stalled; its result passes 4 stages of clamping and add, 8 stages
// of day number to date conversion and 5 of weekday and week numbering.
// Stall from the result side backs up stage by stage, so empty stages still
// fill while the output waits. Result years above YEAR_LIMIT and below 1
// saturate and raise range_flag; new_year carries the year's low 14 bits.
module calendar_date_arithmetic_unit import dca_pkg::*; #(
    parameter int YEAR_LIMIT = 9999
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  logic [1:0]         mode,
    input  logic [13:0]        year,
    input  logic [3:0]         month,
    input  logic [4:0]         day,
    input  logic signed [22:0] offset,
    output logic               result_valid,
    input  logic               result_stall,
    output logic [13:0]        new_year,
    output logic [3:0]         new_month,
    output logic [4:0]         new_day,
    output logic [2:0]         weekday,
    output logic [8:0]         day_of_year,
    output logic [5:0]         week_of_year,
    output logic               leap_flag,
    output logic [4:0]         month_length,
    output logic               input_valid,
    output logic               range_flag
);

    logic      norm_valid;
    logic      norm_stall;
    norm_out_t norm_data;
    logic      fdn_valid;
    logic      fdn_stall;
    date_out_t fdn_data;

    dca_norm #(
        .YEAR_LIMIT(YEAR_LIMIT)
    ) u_norm (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item_valid),
        .in_stall (item_stall),
        .mode     (mode),
        .year     (year),
        .month    (month),
        .day      (day),
        .offset   (offset),
        .out_valid(norm_valid),
        .out_stall(norm_stall),
        .out_data (norm_data)
    );

    dca_fdn u_fdn (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (norm_valid),
        .in_stall (norm_stall),
        .in_data  (norm_data),
        .out_valid(fdn_valid),
        .out_stall(fdn_stall),
        .out_data (fdn_data)
    );

    dca_prop u_prop (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (fdn_valid),
        .in_stall    (fdn_stall),
        .in_data     (fdn_data),
        .out_valid   (result_valid),
        .out_stall   (result_stall),
        .new_year    (new_year),
        .new_month   (new_month),
        .new_day     (new_day),
        .weekday     (weekday),
        .day_of_year (day_of_year),
        .week_of_year(week_of_year),
        .leap_flag   (leap_flag),
        .month_length(month_length),
        .input_valid (input_valid),
        .range_flag  (range_flag)
    );

endmodule

// ----- sv/dca_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the date unit, bound to the top level.
// Depends on calendar_date_arithmetic_unit port names only.
module dca_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               item_valid,
    input logic               item_stall,
    input logic [1:0]         mode,
    input logic [13:0]        year,
    input logic [3:0]         month,
    input logic [4:0]         day,
    input logic signed [22:0] offset,
    input logic               result_valid,
    input logic               result_stall,
    input logic [13:0]        new_year,
    input logic [3:0]         new_month,
    input logic [4:0]         new_day,
    input logic [2:0]         weekday,
    input logic [8:0]         day_of_year,
    input logic [5:0]         week_of_year,
    input logic               leap_flag,
    input logic [4:0]         month_length,
    input logic               input_valid,
    input logic               range_flag
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(new_year)
            && $stable(new_month) && $stable(new_day) && $stable(weekday))
        else $error("result changed while stalled");

    a_day_fits: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> new_day >= 5'd1 && new_day <= month_length
            && new_month >= 4'd1 && new_month <= 4'd12 && weekday <= 3'd6)
        else $error("result date out of calendar");

    a_sat_date: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && range_flag |->
            (new_year == 14'd1 && new_month == 4'd1 && new_day == 5'd1)
            || (new_month == 4'd12 && new_day == 5'd31))
        else $error("saturated result is not a limit date");

    a_feb: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && new_month == 4'd2 |->
            month_length == (leap_flag ? 5'd29 : 5'd28))
        else $error("february length disagrees with leap flag");

    a_week: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> day_of_year >= 9'd1 && day_of_year <= 9'd366
            && week_of_year >= 6'd1 && week_of_year <= 6'd54)
        else $error("day or week of year out of range");

endmodule

bind calendar_date_arithmetic_unit dca_checker u_dca_checker (.*);

// ----- sim/tb_calendar_date_arithmetic_unit.sv -----
`timescale 1ns / 1ps
// Testbench for calendar_date_arithmetic_unit: directed table plus random transactions,
// each result checked against a built-in calendar predictor. Depends on dca_pkg and the RTL.
module tb_calendar_date_arithmetic_unit;
    import dca_pkg::*;

    localparam int YLIM     = 9999;
    localparam int WATCHDOG = 20000;
    localparam int N_RANDOM = 630;

    typedef struct {
        int y, m, d, wd, doy, woy, leap, mlen, ok, sat;
    } date_res_t;

    typedef struct {
        mode_t md;
        int    y, m, d, off;
        bit    typed;
        int    ey, em, ed, eok, esat;
    } stim_row_t;

    logic clk = 0;
    logic rst_n = 0;
    logic item_valid = 0;
    logic item_stall;
    logic [1:0] mode = '0;
    logic [13:0] year = 14'd1;
    logic [3:0] month = 4'd1;
    logic [4:0] day = 5'd1;
    logic signed [22:0] offset = '0;
    logic result_valid;
    logic result_stall = 1;
    logic [13:0] new_year;
    logic [3:0] new_month;
    logic [4:0] new_day;
    logic [2:0] weekday;
    logic [8:0] day_of_year;
    logic [5:0] week_of_year;
    logic leap_flag;
    logic [4:0] month_length;
    logic input_valid;
    logic range_flag;

    date_res_t pending_dates[$];
    int errors = 0;
    int idle_cycles = 0;
    bit stim_done = 0;
    bit long_hold = 0;

    calendar_date_arithmetic_unit dut (.*);

    always #2 clk = ~clk;

    function automatic bit leap_year(longint y);
        return (y % 4 == 0 && y % 100 != 0) || (y % 400 == 0);
    endfunction

    function automatic int days_in_month(longint y, int m);
        case (m)
            2: return leap_year(y) ? 29 : 28;
            4, 6, 9, 11: return 30;
            default: return 31;
        endcase
    endfunction

    function automatic longint days_to_year(longint y);
        longint p = y - 1;
        return p * 365 + p / 4 - p / 100 + p / 400;
    endfunction

    function automatic int days_to_month(longint y, int m);
        int acc = 0;
        for (int i = 1; i < m; i++) acc += days_in_month(y, i);
        return acc;
    endfunction

    function automatic date_res_t predict_date(mode_t md, int yi, int mi, int di, int off);
        date_res_t r;
        longint y = yi, t, dn, lo, hi;
        int m = mi, d = di, rem;
        r.ok = 1;
        r.sat = 0;
        if (y < 1) begin y = 1; r.ok = 0; end
        if (y > YLIM) begin y = YLIM; r.ok = 0; end
        if (m < 1) begin m = 1; r.ok = 0; end
        if (m > 12) begin m = 12; r.ok = 0; end
        if (d < 1) begin d = 1; r.ok = 0; end
        if (d > days_in_month(y, m)) begin d = days_in_month(y, m); r.ok = 0; end
        case (md)
            MODE_DAYS: begin
                lo = 0;
                hi = days_to_year(YLIM + 1) - 1;
                dn = days_to_year(y) + days_to_month(y, m) + d - 1 + off;
                if (dn < lo) begin dn = lo; r.sat = 1; end
                if (dn > hi) begin dn = hi; r.sat = 1; end
                y = dn / 365 + 1;
                while (days_to_year(y) > dn) y--;
                while (days_to_year(y + 1) <= dn) y++;
                rem = int'(dn - days_to_year(y));
                m = 1;
                while (rem >= days_in_month(y, m)) begin
                    rem -= days_in_month(y, m);
                    m++;
                end
                d = rem + 1;
            end
            MODE_MONTHS: begin
                t = y * 12 + (m - 1) + off;
                if (t < 12) begin y = 1; m = 1; d = 1; r.sat = 1; end
                else if (t > YLIM * 12 + 11) begin y = YLIM; m = 12; d = 31; r.sat = 1; end
                else begin
                    y = t / 12;
                    m = int'(t % 12) + 1;
                    if (d > days_in_month(y, m)) d = days_in_month(y, m);
                end
            end
            MODE_YEARS: begin
                t = y + off;
                if (t < 1) begin y = 1; m = 1; d = 1; r.sat = 1; end
                else if (t > YLIM) begin y = YLIM; m = 12; d = 31; r.sat = 1; end
                else begin
                    y = t;
                    if (d > days_in_month(y, m)) d = days_in_month(y, m);
                end
            end
            default: ;
        endcase
        r.y = int'(y);
        r.m = m;
        r.d = d;
        r.doy = days_to_month(y, m) + d;
        r.wd = int'((days_to_year(y) + r.doy) % 7);
        r.woy = (r.doy - 1 + int'((days_to_year(y) + 1 + 6) % 7)) / 7 + 1;
        r.leap = leap_year(y);
        r.mlen = days_in_month(y, m);
        return r;
    endfunction

    task automatic send_date(mode_t md, int y, int m, int d, int off);
        mode <= md;
        year <= y[13:0];
        month <= m[3:0];
        day <= d[4:0];
        offset <= off[22:0];
        item_valid <= 1;
        pending_dates.push_back(predict_date(md, y, m, d, off));
        do @(posedge clk); while (item_stall);
        @(negedge clk);
    endtask

    task automatic send_gap();
        int g = $urandom_range(0, 9) < 7 ? 0 : ($urandom_range(0, 9) < 8 ?
                $urandom_range(1, 3) : $urandom_range(10, 40));
        if (g > 0) begin
            item_valid <= 0;
            repeat (g) @(negedge clk);
        end
    endtask

    task automatic send_random();
        mode_t md;
        int y, m, d, off, sel;
        md = mode_t'($urandom_range(0, 3));
        sel = $urandom_range(0, 19);
        y = $urandom_range(1, YLIM);
        m = $urandom_range(1, 12);
        d = $urandom_range(1, days_in_month(y, m));
        if (sel == 0) begin
            y = $urandom_range(0, 16383);
            m = $urandom_range(0, 15);
            d = $urandom_range(0, 31);
        end
        case ($urandom_range(0, 5))
            0: off = $urandom_range(0, 60) - 30;
            1: off = $urandom_range(0, 2000) - 1000;
            2: off = $urandom_range(0, 8000000) - 4000000;
            3: off = int'({$urandom} % 32'h800000) - 32'h400000;
            4: off = $urandom_range(0, 30000) - 15000;
            default: off = $urandom_range(0, 400) - 200;
        endcase
        send_date(md, y, m, d, off);
    endtask

    stim_row_t dir_tbl[$] = '{
        '{MODE_DAYS, 2000, 1, 1, 0, 1, 2000, 1, 1, 1, 0},
        '{MODE_DAYS, 1, 1, 1, -1, 1, 1, 1, 1, 1, 1},
        '{MODE_DAYS, 9999, 12, 31, 1, 1, 9999, 12, 31, 1, 1},
        '{MODE_DAYS, 5000, 6, 15, -4194304, 1, 1, 1, 1, 1, 1},
        '{MODE_DAYS, 5000, 6, 15, 4194303, 1, 9999, 12, 31, 1, 1},
        '{MODE_DAYS, 0, 0, 0, 0, 1, 1, 1, 1, 0, 0},
        '{MODE_DAYS, 16383, 15, 31, 0, 1, 9999, 12, 31, 0, 0},
        '{MODE_DAYS, 2023, 2, 30, 0, 1, 2023, 2, 28, 0, 0},
        '{MODE_MONTHS, 2024, 1, 31, 1, 1, 2024, 2, 29, 1, 0},
        '{MODE_MONTHS, 2023, 1, 31, 1, 1, 2023, 2, 28, 1, 0},
        '{MODE_MONTHS, 1, 1, 5, -1, 1, 1, 1, 1, 1, 1},
        '{MODE_MONTHS, 9999, 12, 5, 1, 1, 9999, 12, 31, 1, 1},
        '{MODE_MONTHS, 1900, 3, 31, -1, 1, 1900, 2, 28, 1, 0},
        '{MODE_YEARS, 2024, 2, 29, 1, 1, 2025, 2, 28, 1, 0},
        '{MODE_YEARS, 2000, 2, 29, 400, 1, 2400, 2, 29, 1, 0},
        '{MODE_YEARS, 5, 7, 4, -5, 1, 1, 1, 1, 1, 1},
        '{MODE_YEARS, 9000, 7, 4, 1000, 1, 9999, 12, 31, 1, 1},
        '{MODE_NONE, 1999, 13, 31, 77, 1, 1999, 12, 31, 0, 0},
        '{MODE_DAYS, 2017, 1, 1, 0, 0, 0, 0, 0, 0, 0},
        '{MODE_DAYS, 2017, 1, 1, 1, 0, 0, 0, 0, 0, 0},
        '{MODE_DAYS, 2016, 12, 31, 0, 0, 0, 0, 0, 0, 0},
        '{MODE_DAYS, 2000, 2, 28, 1, 0, 0, 0, 0, 0, 0},
        '{MODE_DAYS, 1582, 10, 4, 1, 0, 0, 0, 0, 0, 0},
        '{MODE_DAYS, 8191, 8, 16, -1048576, 0, 0, 0, 0, 0, 0}
    };

    initial begin
        stim_row_t row;
        date_res_t p;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        foreach (dir_tbl[i]) begin
            row = dir_tbl[i];
            if (row.typed) begin
                p = predict_date(row.md, row.y, row.m, row.d, row.off);
                if (p.y != row.ey || p.m != row.em || p.d != row.ed || p.ok != row.eok ||
                        p.sat != row.esat) begin
                    $error("table row %0d disagrees with predictor", i);
                    errors++;
                end
            end
            send_date(row.md, row.y, row.m, row.d, row.off);
            send_gap();
        end
        item_valid <= 0;
        while (pending_dates.size() != 0) @(negedge clk);
        long_hold = 1;
        for (int i = 0; i < N_RANDOM; i++) begin
            send_random();
            if (i == 80) long_hold = 1;
            if (i >= 80 && i < 200) continue;
            send_gap();
        end
        item_valid <= 0;
        stim_done = 1;
    end

    initial begin
        forever begin
            @(negedge clk);
            if (long_hold) begin
                long_hold = 0;
                result_stall <= 1;
                repeat (60) @(negedge clk);
            end else if ($urandom_range(0, 99) < 75) begin
                result_stall <= 0;
            end else begin
                result_stall <= 1;
                if ($urandom_range(0, 9) == 0) repeat ($urandom_range(5, 30)) @(negedge clk);
            end
        end
    end

    always @(posedge clk) begin
        date_res_t e;
        if (rst_n && result_valid && !result_stall) begin
            if (pending_dates.size() == 0) begin
                $error("result with no transaction outstanding");
                errors++;
            end else begin
                e = pending_dates.pop_front();
                if (new_year != e.y[13:0]) begin
                    $error("new_year exp %0d got %0d", e.y, new_year); errors++;
                end
                if (new_month != e.m[3:0]) begin
                    $error("new_month exp %0d got %0d", e.m, new_month); errors++;
                end
                if (new_day != e.d[4:0]) begin
                    $error("new_day exp %0d got %0d", e.d, new_day); errors++;
                end
                if (weekday != e.wd[2:0]) begin
                    $error("weekday exp %0d got %0d", e.wd, weekday); errors++;
                end
                if (day_of_year != e.doy[8:0]) begin
                    $error("day_of_year exp %0d got %0d", e.doy, day_of_year); errors++;
                end
                if (week_of_year != e.woy[5:0]) begin
                    $error("week_of_year exp %0d got %0d", e.woy, week_of_year); errors++;
                end
                if (leap_flag != e.leap[0]) begin
                    $error("leap_flag exp %0d got %0d", e.leap, leap_flag); errors++;
                end
                if (month_length != e.mlen[4:0]) begin
                    $error("month_length exp %0d got %0d", e.mlen, month_length); errors++;
                end
                if (input_valid != e.ok[0]) begin
                    $error("input_valid exp %0d got %0d", e.ok, input_valid); errors++;
                end
                if (range_flag != e.sat[0]) begin
                    $error("range_flag exp %0d got %0d", e.sat, range_flag); errors++;
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        wait (stim_done);
        while (pending_dates.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
